[rtl/core/csp_pkg.sv]
// shared constants, types and codes of the call stack self time profiler
package csp_pkg;

  localparam int THREAD_STACKS = 16;
  localparam int STACK_DEPTH   = 64;
  localparam int TABLE_ENTRIES = 256;

  localparam int STK_W   = (THREAD_STACKS > 1) ? $clog2(THREAD_STACKS) : 1;
  localparam int DEP_W   = $clog2(STACK_DEPTH);
  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
  localparam int FRAME_W = STK_W + DEP_W;
  localparam int TAB_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);

  localparam int DATA_W  = 64;
  localparam int DEPTH_OUT_W = 7;
  localparam int NUM_OUT_W   = 8;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_DISABLED     = 3'd1,
    ST_NO_FREE      = 3'd2,
    ST_OVERFLOW     = 3'd3,
    ST_NO_STACK     = 3'd4,
    ST_NOT_ON_STACK = 3'd5,
    ST_TABLE_FULL   = 3'd6
  } status_e;

  typedef enum logic {
    CFG_ENABLE    = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_CALLER,
    S_FR_RD,
    S_FR_CMP,
    S_KEY_RD,
    S_KEY_CMP,
    S_TOT_RD,
    S_TOT_WAIT,
    S_FINISH
  } state_e;

endpackage

[rtl/core/csp_ram.sv]
// generic single write, single read port ram with registered read data
module csp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/call_stack_self_time_profiler.sv]
// top level: event sequencer, thread stacks, key table and statistics memories
// Each event is taken when start is high and busy is low. Busy then stays high while the
// event runs, and the single result is shown in the same cycle that busy falls: done_o
// is high for exactly one cycle with all result fields, and the receiver cannot stall it.
// A read of an allocated entry reads its totals before it finishes; any other read, an
// unused operation, or an enter or exit that is disabled goes straight to the finishing
// step. Otherwise an event scans the stacks (at most 16), then reads the caller on enter or
// compares frames on exit (at most 64), then compares statistics keys (at most 256). It then
// updates a found entry, allocates and updates a new one, or finishes when the table is full.
// An event may also end after the stack scan. The owner scan walks one stack a cycle through
// a single comparator; the frame search and the key search each take a read state and a
// compare state per element through single read ports.
// No clearing pass is needed after reset.
module call_stack_self_time_profiler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [csp_pkg::DATA_W-1:0]    cfg_wdata_i,
  input  logic [1:0]                    operation_i,
  input  logic [csp_pkg::DATA_W-1:0]    thread_id_i,
  input  logic [csp_pkg::DATA_W-1:0]    func_addr_i,
  input  logic [csp_pkg::DATA_W-1:0]    timestamp_i,
  input  logic [7:0]                    entry_index_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic                          entry_valid_o,
  output logic [7:0]                    entry_number_o,
  output logic [csp_pkg::DATA_W-1:0]    entry_func_o,
  output logic [csp_pkg::DATA_W-1:0]    entry_calls_o,
  output logic [csp_pkg::DATA_W-1:0]    entry_time_o,
  output logic                          reportable_o,
  output logic [6:0]                    depth_after_o
);
  import csp_pkg::*;

  state_e state_q, state_d;
  logic enable_q;
  logic [DATA_W-1:0] thr_q;

  op_e op_q, op_d;
  logic [DATA_W-1:0] tid_q, tid_d, func_q, func_d, ts_q, ts_d;
  logic [DATA_W-1:0] prev_q, prev_d, delta_q, delta_d, key_q, key_d;
  logic [DATA_W-1:0] owner_q [THREAD_STACKS];
  logic [DATA_W-1:0] owner_d [THREAD_STACKS];
  logic [FILL_W-1:0] fill_q [THREAD_STACKS];
  logic [FILL_W-1:0] fill_d [THREAD_STACKS];
  logic [STK_W-1:0] scan_q, scan_d, free_q, free_d, stk_q, stk_d;
  logic free_ok_q, free_ok_d, inc_q, inc_d;
  logic [FILL_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] kidx_q, kidx_d, used_q, used_d;
  logic [TAB_W-1:0] idx_q, idx_d;
  logic [TABLE_ENTRIES-1:0] tvld_q, tvld_d;
  logic tvld_rd_q;

  logic done_q, done_d;
  status_e out_status_q, out_status_d;
  logic out_valid_q, out_valid_d, out_rep_q, out_rep_d;
  logic [NUM_OUT_W-1:0] out_num_q, out_num_d;
  logic [DATA_W-1:0] out_func_q, out_func_d, out_calls_q, out_calls_d, out_time_q, out_time_d;
  logic [DEPTH_OUT_W-1:0] out_depth_q, out_depth_d;

  logic frame_we;
  logic [FRAME_W-1:0] frame_waddr, frame_raddr;
  logic [DATA_W-1:0] frame_rdata;
  logic key_we;
  logic [TAB_W-1:0] key_waddr, key_raddr, tot_addr;
  logic [DATA_W-1:0] key_rdata;
  logic tot_we;
  logic [DATA_W-1:0] calls_wdata, time_wdata, calls_rdata, time_rdata;
  logic [DATA_W-1:0] cur_calls, cur_time;

  logic commit, have, match, is_free, last;
  logic [STK_W-1:0] cstk, s_sel;
  logic [FILL_W-1:0] sfill;

  csp_ram #(.WIDTH(DATA_W), .DEPTH(THREAD_STACKS * STACK_DEPTH)) u_frame_ram (
    .clk_i, .we_i(frame_we), .waddr_i(frame_waddr), .wdata_i(func_q),
    .raddr_i(frame_raddr), .rdata_o(frame_rdata)
  );

  csp_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_q),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  csp_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES)) u_calls_ram (
    .clk_i, .we_i(tot_we), .waddr_i(idx_q), .wdata_i(calls_wdata),
    .raddr_i(tot_addr), .rdata_o(calls_rdata)
  );

  csp_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES)) u_time_ram (
    .clk_i, .we_i(tot_we), .waddr_i(idx_q), .wdata_i(time_wdata),
    .raddr_i(tot_addr), .rdata_o(time_rdata)
  );

  // never written totals read as zero
  assign cur_calls = tvld_rd_q ? calls_rdata : '0;
  assign cur_time  = tvld_rd_q ? time_rdata : '0;

  always_comb begin
    state_d = state_q;
    op_d = op_q; tid_d = tid_q; func_d = func_q; ts_d = ts_q;
    prev_d = prev_q; delta_d = delta_q; key_d = key_q;
    owner_d = owner_q; fill_d = fill_q;
    scan_d = scan_q; free_d = free_q; free_ok_d = free_ok_q; stk_d = stk_q;
    inc_d = inc_q; pos_d = pos_q; kidx_d = kidx_q; used_d = used_q; idx_d = idx_q;
    tvld_d = tvld_q;
    done_d = 1'b0;
    out_status_d = out_status_q; out_valid_d = out_valid_q; out_rep_d = out_rep_q;
    out_num_d = out_num_q; out_func_d = out_func_q; out_calls_d = out_calls_q;
    out_time_d = out_time_q; out_depth_d = out_depth_q;
    frame_we = 1'b0; frame_waddr = '0; frame_raddr = '0;
    key_we = 1'b0; key_waddr = used_q[TAB_W-1:0]; key_raddr = kidx_q[TAB_W-1:0];
    tot_we = 1'b0; tot_addr = idx_q; calls_wdata = '0; time_wdata = '0;
    commit = 1'b0; have = 1'b0; cstk = stk_q; s_sel = stk_q;
    match = 1'b0; is_free = 1'b0; last = 1'b0; sfill = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = op_e'(operation_i);
          tid_d = thread_id_i; func_d = func_addr_i; ts_d = timestamp_i;
          out_status_d = ST_OK; out_valid_d = 1'b0; out_rep_d = 1'b0;
          out_num_d = '0; out_func_d = '0; out_calls_d = '0; out_time_d = '0;
          out_depth_d = '0;
          unique case (op_e'(operation_i))
            OP_ENTER, OP_EXIT: begin
              if (!enable_q) begin
                out_status_d = ST_DISABLED;
                state_d = S_FINISH;
              end else begin
                scan_d = '0; free_ok_d = 1'b0;
                state_d = S_FIND;
              end
            end
            OP_READ: begin
              if (CNT_W'(entry_index_i) < used_q &&
                  32'(entry_index_i) < TABLE_ENTRIES) begin
                idx_d = TAB_W'(entry_index_i);
                key_raddr = TAB_W'(entry_index_i);
                tot_addr = TAB_W'(entry_index_i);
                state_d = S_TOT_WAIT;
              end else begin
                state_d = S_FINISH;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end

      S_FIND: begin
        delta_d = ts_q - prev_q;
        match = owner_q[scan_q] == tid_q;
        is_free = fill_q[scan_q] == '0;
        last = scan_q == STK_W'(THREAD_STACKS - 1);
        if (!free_ok_q && is_free) begin
          free_d = scan_q; free_ok_d = 1'b1;
        end
        if (match) begin
          s_sel = scan_q; have = 1'b1;
        end else if (last) begin
          if (op_q == OP_ENTER && (free_ok_q || is_free)) begin
            s_sel = free_ok_q ? free_q : scan_q;
            have = 1'b1;
            owner_d[s_sel] = tid_q;
          end else begin
            out_status_d = (op_q == OP_ENTER) ? ST_NO_FREE : ST_NO_STACK;
            state_d = S_FINISH;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
        if (have) begin
          stk_d = s_sel; cstk = s_sel;
          sfill = fill_q[s_sel];
          if (op_q == OP_ENTER) begin
            if (32'(sfill) >= STACK_DEPTH) begin
              out_status_d = ST_OVERFLOW;
              out_depth_d = DEPTH_OUT_W'(sfill);
              state_d = S_FINISH;
            end else if (sfill != '0) begin
              frame_raddr = {s_sel, DEP_W'(sfill - 1'b1)};
              state_d = S_CALLER;
            end else begin
              // empty stack: nobody to charge, just push
              commit = 1'b1;
              state_d = S_FINISH;
            end
          end else begin
            pos_d = sfill;
            if (sfill == '0) begin
              out_status_d = ST_NOT_ON_STACK;
              state_d = S_FINISH;
            end else begin
              state_d = S_FR_RD;
            end
          end
        end
      end

      S_CALLER: begin
        key_d = frame_rdata; inc_d = 1'b0; kidx_d = '0;
        state_d = S_KEY_RD;
      end

      S_FR_RD: begin
        frame_raddr = {stk_q, DEP_W'(pos_q - 1'b1)};
        pos_d = pos_q - 1'b1;
        state_d = S_FR_CMP;
      end

      S_FR_CMP: begin
        if (frame_rdata == func_q) begin
          key_d = func_q; inc_d = 1'b1; kidx_d = '0;
          state_d = S_KEY_RD;
        end else if (pos_q == '0) begin
          out_status_d = ST_NOT_ON_STACK;
          out_depth_d = DEPTH_OUT_W'(fill_q[stk_q]);
          state_d = S_FINISH;
        end else begin
          state_d = S_FR_RD;
        end
      end

      S_KEY_RD: begin
        if (kidx_q == used_q) begin
          if (32'(used_q) < TABLE_ENTRIES) begin
            // allocate the next entry
            key_we = 1'b1;
            used_d = used_q + 1'b1;
            idx_d = kidx_q[TAB_W-1:0];
            state_d = S_TOT_RD;
          end else begin
            out_status_d = ST_TABLE_FULL;
            commit = 1'b1;
            state_d = S_FINISH;
          end
        end else begin
          state_d = S_KEY_CMP;
        end
      end

      S_KEY_CMP: begin
        if (key_rdata == key_q) begin
          idx_d = kidx_q[TAB_W-1:0];
          state_d = S_TOT_RD;
        end else begin
          kidx_d = kidx_q + 1'b1;
          state_d = S_KEY_RD;
        end
      end

      S_TOT_RD: begin
        state_d = S_TOT_WAIT;
      end

      S_TOT_WAIT: begin
        tot_we = 1'b1;
        tvld_d[idx_q] = 1'b1;
        out_valid_d = 1'b1;
        out_num_d = NUM_OUT_W'(idx_q);
        if (op_q == OP_READ) begin
          out_func_d = key_rdata;
          out_calls_d = cur_calls;
          out_time_d = cur_time;
        end else begin
          calls_wdata = cur_calls + DATA_W'(inc_q);
          time_wdata = cur_time + delta_q;
          out_func_d = key_q;
          out_calls_d = calls_wdata;
          out_time_d = time_wdata;
          commit = 1'b1;
        end
        state_d = S_FINISH;
      end

      S_FINISH: begin
        out_rep_d = out_valid_q && (out_time_q > thr_q);
        done_d = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // push or pop the stack and take the timestamp
    if (commit) begin
      prev_d = ts_q;
      if (op_q == OP_ENTER) begin
        frame_we = 1'b1;
        frame_waddr = {cstk, DEP_W'(fill_q[cstk])};
        fill_d[cstk] = fill_q[cstk] + 1'b1;
        out_depth_d = DEPTH_OUT_W'(fill_q[cstk] + 1'b1);
      end else begin
        fill_d[cstk] = pos_q;
        out_depth_d = DEPTH_OUT_W'(pos_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      enable_q <= 1'b1;
      thr_q <= '0;
      prev_q <= '0;
      used_q <= '0;
      tvld_q <= '0;
      done_q <= 1'b0;
      stk_q <= '0;
      for (int i = 0; i < THREAD_STACKS; i++) begin
        owner_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      prev_q <= prev_d;
      used_q <= used_d;
      tvld_q <= tvld_d;
      done_q <= done_d;
      stk_q <= stk_d;
      owner_q <= owner_d;
      fill_q <= fill_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_ENABLE:    enable_q <= cfg_wdata_i[0];
          CFG_THRESHOLD: thr_q <= cfg_wdata_i;
          default:       thr_q <= thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; tid_q <= tid_d; func_q <= func_d; ts_q <= ts_d;
    delta_q <= delta_d; key_q <= key_d;
    scan_q <= scan_d; free_q <= free_d; free_ok_q <= free_ok_d;
    inc_q <= inc_d; pos_q <= pos_d; kidx_q <= kidx_d; idx_q <= idx_d;
    tvld_rd_q <= tvld_q[tot_addr];
    out_status_q <= out_status_d; out_valid_q <= out_valid_d; out_rep_q <= out_rep_d;
    out_num_q <= out_num_d; out_func_q <= out_func_d; out_calls_q <= out_calls_d;
    out_time_q <= out_time_d; out_depth_q <= out_depth_d;
  end

  assign busy = state_q != S_IDLE;
  assign done_o = done_q;
  assign status_o = out_status_q;
  assign entry_valid_o = out_valid_q;
  assign entry_number_o = out_num_q;
  assign entry_func_o = out_func_q;
  assign entry_calls_o = out_calls_q;
  assign entry_time_o = out_time_q;
  assign reportable_o = out_rep_q;
  assign depth_after_o = out_depth_q;

`ifndef ASSERT_OFF
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_FINISH))
    else $error("result strobe without finishing step");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result shown while still busy");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= TABLE_ENTRIES)
    else $error("allocated entries beyond table size");

  a_entry_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && out_valid_q) |-> (CNT_W'(out_num_q) < used_q))
    else $error("reported entry was never allocated");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> 32'(fill_q[stk_q]) <= STACK_DEPTH)
    else $error("stack fill beyond its depth");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench of the call stack self time profiler
`timescale 1ns / 100ps

module testbench;
  import csp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct packed {
    status_e     status;
    logic        valid;
    logic [7:0]  number;
    logic [63:0] func;
    logic [63:0] calls;
    logic [63:0] tot_time;
    logic        reportable;
    logic [6:0]  depth;
  } event_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic [1:0]  operation_i;
  logic [63:0] thread_id_i;
  logic [63:0] func_addr_i;
  logic [63:0] timestamp_i;
  logic [7:0]  entry_index_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic        entry_valid_o;
  logic [7:0]  entry_number_o;
  logic [63:0] entry_func_o;
  logic [63:0] entry_calls_o;
  logic [63:0] entry_time_o;
  logic        reportable_o;
  logic [6:0]  depth_after_o;

  call_stack_self_time_profiler dut (.*);

  // profiler state as the checker sees it
  logic        prof_en;
  logic [63:0] report_threshold;
  logic [63:0] stack_thread [THREAD_STACKS];
  int          stack_level  [THREAD_STACKS];
  logic [63:0] frames       [THREAD_STACKS][STACK_DEPTH];
  logic [63:0] entry_key    [TABLE_ENTRIES];
  int          entries_used;
  logic [63:0] call_count   [TABLE_ENTRIES];
  logic [63:0] self_time    [TABLE_ENTRIES];
  logic [63:0] last_stamp;

  event_result_t pending_results[$];
  int            failures;
  int            idle_cycles;
  bit            no_gaps;
  logic [63:0]   thread_pool[20];
  logic [63:0]   func_pool[14];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int find_stack(logic [63:0] tid);
    for (int i = 0; i < THREAD_STACKS; i++)
      if (stack_thread[i] == tid) return i;
    return -1;
  endfunction

  function automatic int claim_stack(logic [63:0] tid);
    for (int i = 0; i < THREAD_STACKS; i++)
      if (stack_level[i] == 0) begin
        stack_thread[i] = tid;
        return i;
      end
    return -1;
  endfunction

  function automatic int entry_for(logic [63:0] key);
    for (int i = 0; i < entries_used; i++)
      if (entry_key[i] == key) return i;
    if (entries_used < TABLE_ENTRIES) begin
      entry_key[entries_used] = key;
      entries_used++;
      return entries_used - 1;
    end
    return -1;
  endfunction

  function automatic void show_entry(inout event_result_t r, input int e,
                                     input logic [63:0] c, input logic [63:0] t);
    r.valid      = 1'b1;
    r.number     = 8'(e);
    r.func       = entry_key[e];
    r.calls      = c;
    r.tot_time   = t;
    r.reportable = t > report_threshold;
  endfunction

  function automatic void charge_entry(inout event_result_t r, input logic [63:0] fn,
                                       input logic [63:0] elapsed, input logic [63:0] n);
    int e;
    e = entry_for(fn);
    if (e < 0) begin
      r.status = ST_TABLE_FULL;
      return;
    end
    call_count[e] += n;
    self_time[e]  += elapsed;
    show_entry(r, e, call_count[e], self_time[e]);
  endfunction

  function automatic event_result_t predict_event(op_e op, logic [63:0] tid,
                                                  logic [63:0] fn, logic [63:0] ts,
                                                  logic [7:0] ix);
    event_result_t r;
    int s;
    int pos;
    r = '0;
    case (op)
      OP_ENTER: begin
        if (!prof_en) begin
          r.status = ST_DISABLED;
          return r;
        end
        s = find_stack(tid);
        if (s < 0) s = claim_stack(tid);
        if (s < 0) begin
          r.status = ST_NO_FREE;
          return r;
        end
        if (stack_level[s] >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
          r.depth  = 7'(stack_level[s]);
          return r;
        end
        if (stack_level[s] > 0)
          charge_entry(r, frames[s][stack_level[s]-1], ts - last_stamp, 64'd0);
        last_stamp = ts;
        frames[s][stack_level[s]] = fn;
        stack_level[s]++;
        r.depth = 7'(stack_level[s]);
      end
      OP_EXIT: begin
        if (!prof_en) begin
          r.status = ST_DISABLED;
          return r;
        end
        s = find_stack(tid);
        if (s < 0) begin
          r.status = ST_NO_STACK;
          return r;
        end
        for (pos = stack_level[s] - 1; pos >= 0; pos--)
          if (frames[s][pos] == fn) break;
        if (pos < 0) begin
          r.status = ST_NOT_ON_STACK;
          r.depth  = 7'(stack_level[s]);
          return r;
        end
        stack_level[s] = pos;
        charge_entry(r, fn, ts - last_stamp, 64'd1);
        last_stamp = ts;
        r.depth = 7'(stack_level[s]);
      end
      OP_READ: begin
        if (ix < entries_used) begin
          show_entry(r, ix, call_count[ix], self_time[ix]);
          call_count[ix] = '0;
          self_time[ix]  = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_event(op_e op, logic [63:0] tid, logic [63:0] fn,
                            logic [63:0] ts, logic [7:0] ix);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    operation_i   <= op;
    thread_id_i   <= tid;
    func_addr_i   <= fn;
    timestamp_i   <= ts;
    entry_index_i <= ix;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_event(op, tid, fn, ts, ix));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_e idx, logic [63:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ENABLE) prof_en = value[0];
    else report_threshold = value;
  endtask

  // result check
  always @(posedge clk_i) begin
    event_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o != exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, status_o); failures++;
        end
        if (entry_valid_o != exp_r.valid) begin
          $error("entry_valid exp %0d got %0d", exp_r.valid, entry_valid_o); failures++;
        end
        if (entry_number_o != exp_r.number) begin
          $error("entry_number exp %0d got %0d", exp_r.number, entry_number_o); failures++;
        end
        if (entry_func_o != exp_r.func) begin
          $error("entry_func exp %h got %h", exp_r.func, entry_func_o); failures++;
        end
        if (entry_calls_o != exp_r.calls) begin
          $error("entry_calls exp %0d got %0d", exp_r.calls, entry_calls_o); failures++;
        end
        if (entry_time_o != exp_r.tot_time) begin
          $error("entry_time exp %0d got %0d", exp_r.tot_time, entry_time_o); failures++;
        end
        if (reportable_o != exp_r.reportable) begin
          $error("reportable exp %0d got %0d", exp_r.reportable, reportable_o); failures++;
        end
        if (depth_after_o != exp_r.depth) begin
          $error("depth_after exp %0d got %0d", exp_r.depth, depth_after_o); failures++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken and no result shown
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    logic [63:0] fa, fb, tx;
    fa = 64'h0000_1000_0000_0040;
    fb = 64'h0000_1000_0000_0400;
    tx = 64'hdead_0000_0000_0001;
    send_event(OP_ENTER, 64'd0, fa, 64'd10, 8'd0);   // empty stack, no caller
    send_event(OP_ENTER, 64'd0, fb, 64'd25, 8'd0);
    send_event(OP_ENTER, 64'd0, fa, 64'd30, 8'd0);   // recursion
    send_event(OP_EXIT,  64'd0, fa, 64'd40, 8'd0);
    send_event(OP_EXIT,  64'd0, fb, 64'd50, 8'd0);
    send_event(OP_EXIT,  64'd0, fa, 64'd5, 8'd0);    // timestamp going backwards
    send_event(OP_EXIT,  64'd0, fb, 64'd60, 8'd0);   // empty stack
    send_event(OP_EXIT,  tx,    fa, 64'd70, 8'd0);   // thread with no stack
    send_event(OP_NOP,   '1,    '1, '1, 8'hff);
    send_event(OP_READ,  '0,    '0, '0, 8'd0);
    send_event(OP_READ,  '1,    '1, '1, 8'd1);
    send_event(OP_READ,  '0,    '0, '0, 8'd255);     // beyond the table fill
    send_event(OP_ENTER, '1,    '1, '1, 8'hff);
    send_event(OP_ENTER, '1,    '0, '0, 8'd0);
    send_event(OP_EXIT,  '1,    fb, 64'd3, 8'd0);    // not on the stack
    send_event(OP_EXIT,  '1,    '1, 64'h8000_0000_0000_0000, 8'd0);
    send_event(OP_READ,  '0,    '0, '0, 8'd2);
    send_event(OP_READ,  '0,    '0, '0, 8'd3);
    drain_results();
  endtask

  task automatic test_registers();
    write_register(CFG_ENABLE, 64'd0);
    send_event(OP_ENTER, 64'd0, 64'h55, 64'd100, 8'd0);
    send_event(OP_EXIT,  64'd0, 64'h55, 64'd120, 8'd0);
    send_event(OP_READ,  64'd0, 64'h0, 64'd0, 8'd0);   // reads still served
    write_register(CFG_ENABLE, 64'hffff_ffff_ffff_fffe); // bit 0 low
    send_event(OP_ENTER, 64'd7, 64'h56, 64'd130, 8'd0);
    write_register(CFG_ENABLE, '1);
    write_register(CFG_THRESHOLD, '1);
    send_event(OP_ENTER, 64'd0, 64'h77, 64'd0, 8'd0);
    send_event(OP_EXIT,  64'd0, 64'h77, '1, 8'd0);
    write_register(CFG_THRESHOLD, 64'd20);
    send_event(OP_ENTER, 64'd0, 64'h78, 64'd200, 8'd0);
    send_event(OP_EXIT,  64'd0, 64'h78, 64'd220, 8'd0); // equal, not above
    send_event(OP_ENTER, 64'd0, 64'h78, 64'd230, 8'd0);
    send_event(OP_EXIT,  64'd0, 64'h78, 64'd251, 8'd0);
    drain_results();
  endtask

  task automatic test_stack_limits();
    logic [63:0] tid;
    bit any_free;
    int s;
    // thread 0 need not own stack 0 by now
    send_event(OP_ENTER, 64'd0, rand64(), last_stamp + 3, 8'd0);
    s = find_stack(64'd0);
    while (stack_level[s] < STACK_DEPTH)
      send_event(OP_ENTER, 64'd0, rand64(), last_stamp + 3, 8'd0);
    send_event(OP_ENTER, 64'd0, 64'h99, last_stamp + 3, 8'd0);   // overflow
    send_event(OP_EXIT,  64'd0, frames[s][0], last_stamp + 9, 8'd0);
    do begin
      any_free = 1'b0;
      for (int i = 0; i < THREAD_STACKS; i++) if (stack_level[i] == 0) any_free = 1'b1;
      if (any_free) send_event(OP_ENTER, rand64(), rand64(), last_stamp + 2, 8'd0);
    end while (any_free);
    tid = rand64();
    send_event(OP_ENTER, tid, 64'h42, last_stamp + 1, 8'd0);      // no free stack
    send_event(OP_EXIT,  tid, 64'h42, last_stamp + 1, 8'd0);
    for (int i = 0; i < THREAD_STACKS; i++)
      if (stack_level[i] > 0)
        send_event(OP_EXIT, stack_thread[i], frames[i][0], last_stamp + 4, 8'd0);
    drain_results();
  endtask

  task automatic random_phase(int count);
    logic [63:0] tid, fn, ts;
    logic [7:0] ix;
    int s, pick;
    op_e op;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      op = pick < 45 ? OP_ENTER : pick < 80 ? OP_EXIT : pick < 96 ? OP_READ : OP_NOP;
      tid = thread_pool[$urandom_range(0, 19)];
      fn  = func_pool[$urandom_range(0, 13)];
      ts  = ($urandom_range(0, 19) == 0) ? rand64() : last_stamp + $urandom_range(0, 300);
      ix  = 8'($urandom_range(0, 255));
      if (op == OP_READ && $urandom_range(0, 3) != 0 && entries_used > 0)
        ix = 8'($urandom_range(0, entries_used - 1));
      s = find_stack(tid);
      if (op == OP_EXIT && s >= 0 && stack_level[s] > 0 && $urandom_range(0, 9) < 7)
        fn = frames[s][$urandom_range(0, stack_level[s] - 1)];
      if (op == OP_NOP || op == OP_READ) begin
        tid = rand64();
        fn  = rand64();
      end
      send_event(op, tid, fn, ts, ix);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    foreach (thread_pool[i]) thread_pool[i] = (i == 0) ? 64'd0 : rand64();
    foreach (func_pool[i]) func_pool[i] = rand64();
    func_pool[0] = '1;
    func_pool[1] = '0;
    random_phase(50);
    write_register(CFG_THRESHOLD, 64'd150);
    random_phase(50);
    write_register(CFG_THRESHOLD, 64'd0);
    random_phase(50);
    drain_results();
  endtask

  task automatic test_table_full();
    logic [63:0] fn;
    int s;
    // empty every stack so that thread 0 always finds one
    for (int i = 0; i < THREAD_STACKS; i++)
      if (stack_level[i] > 0)
        send_event(OP_EXIT, stack_thread[i], frames[i][0], last_stamp + 1, 8'd0);
    no_gaps = 1'b1;
    // each push on a non-empty stack charges a fresh caller
    while (entries_used < TABLE_ENTRIES) begin
      s = find_stack(64'd0);
      if (s >= 0 && stack_level[s] >= STACK_DEPTH)
        send_event(OP_EXIT, 64'd0, frames[s][0], last_stamp + 7, 8'd0);
      else
        send_event(OP_ENTER, 64'd0, rand64(), last_stamp + 5, 8'd0);
    end
    no_gaps = 1'b0;
    s = find_stack(64'd0);
    if (s >= 0 && stack_level[s] > 0)
      send_event(OP_EXIT, 64'd0, frames[s][0], last_stamp + 1, 8'd0);
    fn = rand64();
    send_event(OP_ENTER, 64'd0, fn, last_stamp + 5, 8'd0);
    send_event(OP_ENTER, 64'd0, rand64(), last_stamp + 5, 8'd0);  // caller has no entry
    send_event(OP_EXIT,  64'd0, fn, last_stamp + 5, 8'd0);        // table full on exit
    send_event(OP_READ,  64'd0, 64'd0, 64'd0, 8'd255);
    send_event(OP_READ,  64'd0, 64'd0, 64'd0, 8'd0);
    send_event(OP_READ,  64'd0, 64'd0, 64'd0, 8'd255);
    drain_results();
  endtask

  initial begin
    start = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = CFG_ENABLE; cfg_wdata_i = '0;
    operation_i = OP_NOP; thread_id_i = '0; func_addr_i = '0;
    timestamp_i = '0; entry_index_i = '0;
    failures = 0; no_gaps = 1'b0;
    prof_en = 1'b1; report_threshold = '0; entries_used = 0; last_stamp = '0;
    foreach (stack_thread[i]) begin
      stack_thread[i] = '0;
      stack_level[i]  = 0;
    end
    foreach (call_count[i]) begin
      call_count[i] = '0;
      self_time[i]  = '0;
    end
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_stack_limits();
    test_random();
    test_table_full();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
